### rtl/hkm_pkg.sv
// Shared types, codes and constants of the hotkey match table.
package hkm_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int MOD_W  = 8;
  localparam int KEY_W  = 16;
  localparam int APP_W  = 8;
  localparam int HID_W  = 4;
  localparam int ACT_W  = 8;
  localparam int CNT_W  = 6;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 1;

  localparam logic [APP_W-1:0] APP_LIMIT_RST = 8'd16;

  localparam logic [CIDX_W-1:0] CFG_ACTIVE = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_LIMIT  = 1'd1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ENABLE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_DUP      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LAUNCH = 2'd1,
    ACT_RUN    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [MOD_W-1:0] mods;
    logic [KEY_W-1:0] key;
    logic [APP_W-1:0] app;
    logic             hvalid;
    logic [HID_W-1:0] hid;
    logic             en;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    step;
    logic    shift_mode;
    logic    shift_start;
    logic    wr_insert;
    logic    wr_enable;
    logic    dec_count;
    logic    set_res;
    status_t res_code;
    logic    res_act;
    logic    post;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    ins_full;
    logic    hit;
    logic    scan_done;
    logic    out_free;
  } stat_t;

endpackage

### rtl/hkm_if.sv
// Request and response channel interfaces of the hotkey match table.
interface hkm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] modifiers;
  logic [15:0] key_val;
  logic [7:0] app_id;
  logic       handler_valid;
  logic [3:0] handler_id;
  logic       enable_value;

  modport source (output valid, opcode, modifiers, key_val, app_id, handler_valid,
                  handler_id, enable_value, input ready);
  modport sink (input valid, opcode, modifiers, key_val, app_id, handler_valid,
                handler_id, enable_value, output ready);
endinterface

interface hkm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] action_kind;
  logic [7:0] action_id;
  logic [5:0] entry_count;

  modport source (output valid, status, action_kind, action_id, entry_count, input ready);
  modport sink (input valid, status, action_kind, action_id, entry_count, output ready);
endinterface

### rtl/hotkey_match_table.sv
// Hotkey match table: one request beat in, one response beat out. Entries live in a
// single-port-read memory walked one entry per cycle, so lookup, insert and set-enable
// scan the used entries in order until a match, and remove scans to the matching entry,
// then shifts the rest down one per cycle; a response held off by the receiver stalls
// the next request. A finished response waits in an output register while the next
// request is taken. No clearing pass is needed after reset.
module hotkey_match_table #(
  parameter int ENTRIES = hkm_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hkm_pkg::CIDX_W-1:0] cfg_index,
  input  logic [hkm_pkg::CFG_W-1:0]  cfg_data,
  hkm_req_if.sink                    req,
  hkm_rsp_if.source                  rsp
);
  import hkm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hkm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hkm_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (req.opcode),
    .modifiers     (req.modifiers),
    .key_val       (req.key_val),
    .app_id        (req.app_id),
    .handler_valid (req.handler_valid),
    .handler_id    (req.handler_id),
    .enable_value  (req.enable_value),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .action_kind   (rsp.action_kind),
    .action_id     (rsp.action_id),
    .entry_count   (rsp.entry_count),
    .cmd           (cmd),
    .stat          (stat)
  );

  // never append to a full table
  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_insert |-> !stat.ins_full)
    else $error("insert write issued on a full table");

  // one request at a time: after a beat is taken, no further beat next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

  // a response is only loaded into a free output register
  a_post_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> stat.out_free)
    else $error("response overwrote a pending beat");

endmodule

### rtl/hkm_datapath.sv
// Datapath: entry memory, scan and shift pointers, config and result registers.
module hkm_datapath #(
  parameter int ENTRIES = hkm_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hkm_pkg::CIDX_W-1:0] cfg_index,
  input  logic [hkm_pkg::CFG_W-1:0]  cfg_data,
  input  logic [1:0]                 opcode,
  input  logic [hkm_pkg::MOD_W-1:0]  modifiers,
  input  logic [hkm_pkg::KEY_W-1:0]  key_val,
  input  logic [hkm_pkg::APP_W-1:0]  app_id,
  input  logic                       handler_valid,
  input  logic [hkm_pkg::HID_W-1:0]  handler_id,
  input  logic                       enable_value,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [1:0]                 status,
  output logic [1:0]                 action_kind,
  output logic [hkm_pkg::ACT_W-1:0]  action_id,
  output logic [hkm_pkg::CNT_W-1:0]  entry_count,
  input  hkm_pkg::cmd_t              cmd,
  output hkm_pkg::stat_t             stat
);
  import hkm_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  entry_t mem [ENTRIES];
  entry_t rdata;

  logic             active;
  logic [APP_W-1:0] limit;
  opcode_t          op_q;
  logic [MOD_W-1:0] mods_q;
  logic [KEY_W-1:0] key_q;
  logic [APP_W-1:0] app_q;
  logic             hv_q;
  logic [HID_W-1:0] hid_q;
  logic             en_q;

  logic [CW-1:0] used;
  logic [CW-1:0] rptr;
  logic [CW-1:0] ridx;
  logic          pend;

  status_t          res_code;
  kind_t            res_kind;
  logic [ACT_W-1:0] res_id;

  logic          rd_now;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          pair_eq;
  logic          usable;
  logic [CW-1:0] ridx_dec;

  assign rd_now   = cmd.step && (rptr < used);
  assign ridx_dec = ridx - CW'(1);
  assign pair_eq  = (rdata.mods == mods_q) && (rdata.key == key_q);
  assign usable   = active && rdata.en && (rdata.hvalid || (rdata.app < limit));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ridx[IW-1:0];
    wr_data = rdata;
    if (cmd.step && cmd.shift_mode && pend) begin
      // move the entry just read one place down
      wr_en   = 1'b1;
      wr_addr = ridx_dec[IW-1:0];
    end else if (cmd.wr_insert) begin
      wr_en   = 1'b1;
      wr_addr = used[IW-1:0];
      wr_data = '{mods: mods_q, key: key_q, app: app_q, hvalid: hv_q, hid: hid_q,
                  en: 1'b1};
    end else if (cmd.wr_enable) begin
      wr_en      = 1'b1;
      wr_data.en = en_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_now) begin
      rdata <= mem[rptr[IW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      limit     <= APP_LIMIT_RST;
      used      <= '0;
      rptr      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE: active <= cfg_data[0];
          CFG_LIMIT:  limit  <= cfg_data[APP_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.scan_start) begin
        rptr <= '0;
        pend <= 1'b0;
      end else if (cmd.shift_start) begin
        rptr <= ridx + CW'(1);
        pend <= 1'b0;
      end else if (cmd.step) begin
        pend <= rd_now;
        if (rd_now) begin
          rptr <= rptr + CW'(1);
        end
      end
      if (cmd.wr_insert) begin
        used <= used + CW'(1);
      end else if (cmd.dec_count) begin
        used <= used - CW'(1);
      end
      if (cmd.post) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode_t'(opcode);
      mods_q <= modifiers;
      key_q  <= key_val;
      app_q  <= app_id;
      hv_q   <= handler_valid;
      hid_q  <= handler_id;
      en_q   <= enable_value;
    end
    if (rd_now) begin
      ridx <= rptr;
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
      res_kind <= ACT_NONE;
      res_id   <= '0;
      if (cmd.res_act) begin
        if (rdata.hvalid) begin
          res_kind <= ACT_RUN;
          res_id   <= ACT_W'(rdata.hid);
        end else begin
          res_kind <= ACT_LAUNCH;
          res_id   <= rdata.app;
        end
      end
    end
    if (cmd.post) begin
      status      <= res_code;
      action_kind <= res_kind;
      action_id   <= res_id;
      entry_count <= CNT_W'(used);
    end
  end

  assign stat.op        = op_q;
  assign stat.ins_full  = (op_q == OP_INSERT) && (used >= CW'(ENTRIES));
  assign stat.hit       = pend && pair_eq && ((op_q != OP_LOOKUP) || usable);
  assign stat.scan_done = !pend && (rptr >= used);
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

### rtl/hkm_ctrl.sv
// Controller: sequences scan, shift and result hand-off for each request.
module hkm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  hkm_pkg::stat_t stat,
  output hkm_pkg::cmd_t  cmd
);
  import hkm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_POST
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.ins_full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_POST;
        end else if (stat.hit) begin
          case (stat.op)
            OP_LOOKUP: begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_DONE;
              cmd.res_act  = 1'b1;
              state_next   = S_POST;
            end
            OP_INSERT: begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_DUP;
              state_next   = S_POST;
            end
            OP_REMOVE: begin
              cmd.shift_start = 1'b1;
              state_next      = S_SHIFT;
            end
            default: begin
              cmd.wr_enable = 1'b1;
              cmd.set_res   = 1'b1;
              cmd.res_code  = ST_DONE;
              state_next    = S_POST;
            end
          endcase
        end else if (stat.scan_done) begin
          cmd.set_res = 1'b1;
          if (stat.op == OP_INSERT) begin
            cmd.wr_insert = 1'b1;
            cmd.res_code  = ST_DONE;
          end else begin
            cmd.res_code = ST_NO_MATCH;
          end
          state_next = S_POST;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.step       = 1'b1;
        cmd.shift_mode = 1'b1;
        if (stat.scan_done) begin
          cmd.dec_count = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_code  = ST_DONE;
          state_next    = S_POST;
        end
      end
      S_POST: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
